### src/ssbm_pkg.sv
// Shared types, constants and the segment decoder for the seven-segment blink multiplexer.
// Depends on nothing; used by the top level and the testbench.
package ssbm_pkg;

	// Display mode codes carried by the mode field.
	typedef enum logic [1:0] {
		MODE_NORMAL      = 2'd0,
		MODE_SET_HOURS   = 2'd1,
		MODE_SET_MINUTES = 2'd2,
		MODE_DARK        = 2'd3
	} mode_t;

	localparam int unsigned DIGIT_COUNT = 4;
	localparam int unsigned DIGIT_W     = $clog2(DIGIT_COUNT);

	localparam logic [7:0] BLINK_LIMIT_RESET = 8'd10;
	localparam logic [7:0] DP_BIT            = 8'b1000_0000;
	localparam logic [DIGIT_W-1:0] DP_DIGIT  = DIGIT_W'(DIGIT_COUNT - 1);

	// Symbol code to segments a-g; codes ten and above are blank.
	function automatic logic [7:0] seg_decode(input logic [3:0] sym);
		logic [7:0] seg;
		case (sym)
			4'd0: seg = 8'b0011_1111;
			4'd1: seg = 8'b0000_0110;
			4'd2: seg = 8'b0101_1011;
			4'd3: seg = 8'b0100_1111;
			4'd4: seg = 8'b0110_0110;
			4'd5: seg = 8'b0110_1101;
			4'd6: seg = 8'b0111_1101;
			4'd7: seg = 8'b0000_0111;
			4'd8: seg = 8'b0111_1111;
			4'd9: seg = 8'b0110_1111;
			default: seg = 8'b0000_0000;
		endcase
		return seg;
	endfunction

endpackage

### src/seven_segment_blink_multiplexer.sv
// Top level of the four-digit seven-segment blink multiplexer.
// Depends on ssbm_pkg for mode codes, reset constants and the segment decoder.

// Each accepted input beat is one refresh tick: the block shows the digit under its scan
// pointer, then advances the pointer from the leftmost digit to the rightmost and wraps.
// A beat passes through an input register and a result register, and one beat is taken
// every cycle while results are being taken; the scan pointer and the two blink counters
// update together as a beat moves from the input register to the result register. The
// blink_limit write port is always ready and should be written only while no beats are
// in flight. In the two set modes each digit of the blinking pair counts its own visits
// and toggles its on/off phase after blink_limit+1 visits; the segment pattern is driven
// even when no digit is enabled.
module seven_segment_blink_multiplexer (
	input  logic       clk,
	input  logic       arst_n,
	// Input item channel.
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [3:0] sym_digit0,
	input  logic [3:0] sym_digit1,
	input  logic [3:0] sym_digit2,
	input  logic [3:0] sym_digit3,
	input  logic [1:0] mode,
	input  logic       decimal_point,
	// Result channel.
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] segments,
	output logic [3:0] digit_enable,
	// Configuration write channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] blink_limit
);

	logic                           valid_s1;
	logic [3:0]                     sym_s1 [ssbm_pkg::DIGIT_COUNT];
	ssbm_pkg::mode_t                mode_s1;
	logic                           dp_s1;
	logic                           out_valid_q;
	logic [7:0]                     segments_q;
	logic [3:0]                     digit_enable_q;
	logic [7:0]                     blink_limit_q;
	logic [ssbm_pkg::DIGIT_W-1:0]   scan_q;
	logic [1:0]                     blink_phase_q;
	logic [7:0]                     blink_count_q [2];

	logic                           advance;
	logic [3:0]                     cur_sym;
	logic [7:0]                     seg_next;
	logic                           set_mode;
	logic                           blink_hit;
	logic                           slot;
	logic                           lit;
	logic [3:0]                     en_next;

	// Handshake: the result register frees up when it is empty or being taken.
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sym_s1[0] <= sym_digit0;
			sym_s1[1] <= sym_digit1;
			sym_s1[2] <= sym_digit2;
			sym_s1[3] <= sym_digit3;
			mode_s1   <= ssbm_pkg::mode_t'(mode);
			dp_s1     <= decimal_point;
		end
	end

	// Segment pattern of the scanned digit, with the decimal point on the rightmost one.
	always_comb begin
		cur_sym  = sym_s1[scan_q];
		seg_next = ssbm_pkg::seg_decode(cur_sym);
		if (scan_q == ssbm_pkg::DP_DIGIT && dp_s1) begin
			seg_next = seg_next | ssbm_pkg::DP_BIT;
		end
	end

	// Blink decision: the upper scan bit picks the pair, the lower bit picks the slot.
	always_comb begin
		set_mode  = (mode_s1 == ssbm_pkg::MODE_SET_HOURS) ||
			(mode_s1 == ssbm_pkg::MODE_SET_MINUTES);
		blink_hit = set_mode &&
			(scan_q[1] == (mode_s1 == ssbm_pkg::MODE_SET_MINUTES));
		slot      = scan_q[0];
		case (mode_s1)
			ssbm_pkg::MODE_NORMAL:      lit = 1'b1;
			ssbm_pkg::MODE_SET_HOURS,
			ssbm_pkg::MODE_SET_MINUTES: lit = !blink_hit || blink_phase_q[slot];
			default:                    lit = 1'b0;
		endcase
		en_next = lit ? (4'b0001 << scan_q) : 4'b0000;
	end

	// Scan pointer, blink state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q           <= '0;
			blink_phase_q    <= '0;
			blink_count_q[0] <= '0;
			blink_count_q[1] <= '0;
			blink_limit_q    <= ssbm_pkg::BLINK_LIMIT_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				blink_limit_q <= blink_limit;
			end
			if (advance) begin
				scan_q <= scan_q + 1'b1;
				if (blink_hit) begin
					if (blink_count_q[slot] < blink_limit_q) begin
						blink_count_q[slot] <= blink_count_q[slot] + 8'd1;
					end else begin
						blink_count_q[slot] <= '0;
						blink_phase_q[slot] <= !blink_phase_q[slot];
					end
				end
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			segments_q     <= seg_next;
			digit_enable_q <= en_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign segments     = segments_q;
	assign digit_enable = digit_enable_q;

endmodule

### src/ssbm_checker.sv
// Port-level checker for the seven-segment blink multiplexer, with its bind statement.
// Depends on the top level's port list; attaches to seven_segment_blink_multiplexer.
module ssbm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] segments,
	input logic [3:0] digit_enable,
	input logic       cfg_ready
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(segments) && $stable(digit_enable))
		else $error("result beat changed while stalled");

	// At most one digit lights per result.
	a_one_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0(digit_enable))
		else $error("more than one digit enabled");

	// The decimal point only ever accompanies the rightmost digit.
	a_dp_rightmost: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && segments[7] && digit_enable != 4'b0000 |-> digit_enable == 4'b1000)
		else $error("decimal point shown on a digit other than the rightmost");

	// The register write port never stalls.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port stalled");

endmodule

bind seven_segment_blink_multiplexer ssbm_checker u_ssbm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.segments     (segments),
	.digit_enable (digit_enable),
	.cfg_ready    (cfg_ready)
);

### tb/tb_seven_segment_blink_multiplexer.sv
// Self-checking testbench for the four-digit seven-segment blink multiplexer.
// Depends on ssbm_pkg and seven_segment_blink_multiplexer; predicts every result beat in place.
module tb_seven_segment_blink_multiplexer;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 3000;
	localparam int LONG_HOLD   = 300;

	// One refresh request as offered on the input channel.
	typedef struct packed {
		logic [3:0][3:0] sym;
		ssbm_pkg::mode_t mode;
		logic            dp;
	} refresh_beat_t;

	// One result beat: the segment pattern and the digit enables.
	typedef struct packed {
		logic [7:0] segments;
		logic [3:0] enable;
	} display_frame_t;

	// Segments a-g for the numerals zero to nine.
	localparam logic [6:0] GLYPH [10] = '{
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [3:0] sym_digit0 = '0;
	logic [3:0] sym_digit1 = '0;
	logic [3:0] sym_digit2 = '0;
	logic [3:0] sym_digit3 = '0;
	logic [1:0] mode = '0;
	logic       decimal_point = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] segments;
	logic [3:0] digit_enable;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] blink_limit = '0;

	refresh_beat_t  pending_beats[$];
	display_frame_t expected_frames[$];
	refresh_beat_t  offered = '0;

	int beats_queued = 0;
	int beats_accepted = 0;
	int error_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// Shadow copy of the display state and the blink limit.
	logic [1:0] shadow_scan = '0;
	logic       shadow_phase [2] = '{1'b0, 1'b0};
	logic [7:0] shadow_count [2] = '{8'd0, 8'd0};
	logic [7:0] shadow_limit = ssbm_pkg::BLINK_LIMIT_RESET;

	seven_segment_blink_multiplexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sym_digit0(sym_digit0),
		.sym_digit1(sym_digit1),
		.sym_digit2(sym_digit2),
		.sym_digit3(sym_digit3),
		.mode(mode),
		.decimal_point(decimal_point),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.segments(segments),
		.digit_enable(digit_enable),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.blink_limit(blink_limit)
	);

	always #5 clk = ~clk;

	// A visit to a blinking digit: count it, flip the phase past the limit.
	// The digit lights only if its phase was on before the visit.
	function automatic logic visit_blinker(input int slot);
		logic was_on;
		was_on = shadow_phase[slot];
		if (shadow_count[slot] < shadow_limit) begin
			shadow_count[slot] = shadow_count[slot] + 8'd1;
		end else begin
			shadow_count[slot] = 8'd0;
			shadow_phase[slot] = ~shadow_phase[slot];
		end
		return was_on;
	endfunction

	// Work out the frame that one refresh beat shows, and advance the scan.
	function automatic display_frame_t predict_frame(input refresh_beat_t beat);
		display_frame_t frame;
		logic [1:0]     pos;
		logic [3:0]     sym;
		logic [1:0]     pair_base;
		logic           lit;
		pos = shadow_scan;
		sym = beat.sym[pos];
		lit = 1'b0;
		frame.segments = (sym < 4'd10) ? {1'b0, GLYPH[sym]} : 8'h00;
		if (pos == 2'd3 && beat.dp) begin
			frame.segments = frame.segments | ssbm_pkg::DP_BIT;
		end
		case (beat.mode)
			ssbm_pkg::MODE_NORMAL: begin
				lit = 1'b1;
			end
			ssbm_pkg::MODE_SET_HOURS, ssbm_pkg::MODE_SET_MINUTES: begin
				pair_base = (beat.mode == ssbm_pkg::MODE_SET_HOURS) ? 2'd0 : 2'd2;
				if (pos == pair_base) begin
					lit = visit_blinker(0);
				end else if (pos == pair_base + 2'd1) begin
					lit = visit_blinker(1);
				end else begin
					lit = 1'b1;
				end
			end
			default: begin
				lit = 1'b0;
			end
		endcase
		frame.enable = lit ? (4'b0001 << pos) : 4'b0000;
		shadow_scan = pos + 2'd1;
		return frame;
	endfunction

	// Driver: predict each accepted beat, then offer the next pending one.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_frames.push_back(predict_frame(offered));
				beats_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = pending_beats.pop_front();
					in_valid <= 1'b1;
					sym_digit0 <= offered.sym[0];
					sym_digit1 <= offered.sym[1];
					sym_digit2 <= offered.sym[2];
					sym_digit3 <= offered.sym[3];
					mode <= offered.mode;
					decimal_point <= offered.dp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat, then pick out_ready for the next cycle.
	always @(posedge clk) begin
		display_frame_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					$error("result beat with nothing expected: segments %h enable %b",
						segments, digit_enable);
					error_count++;
				end else begin
					want = expected_frames.pop_front();
					if (segments !== want.segments) begin
						$error("segments: expected %h, got %h", want.segments, segments);
						error_count++;
					end
					if (digit_enable !== want.enable) begin
						$error("digit_enable: expected %b, got %b", want.enable, digit_enable);
						error_count++;
					end
				end
			end
			// A requested long hold backs up the block while the sender keeps offering.
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = LONG_HOLD;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: give up when no channel has moved a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic refresh_beat_t random_beat(input ssbm_pkg::mode_t beat_mode);
		refresh_beat_t beat;
		for (int d = 0; d < 4; d++) begin
			beat.sym[d] = 4'($urandom_range(15));
		end
		beat.mode = beat_mode;
		beat.dp = 1'($urandom_range(1));
		return beat;
	endfunction

	// Random content in runs of one mode, so blink phases get to flip while in use.
	task automatic queue_random_runs(input int count);
		int              added;
		int              run_len;
		int              pick;
		ssbm_pkg::mode_t run_mode;
		added = 0;
		while (added < count) begin
			run_len = $urandom_range(1, 48);
			pick = $urandom_range(99);
			run_mode = (pick < 15) ? ssbm_pkg::MODE_NORMAL :
				(pick < 50) ? ssbm_pkg::MODE_SET_HOURS :
				(pick < 85) ? ssbm_pkg::MODE_SET_MINUTES : ssbm_pkg::MODE_DARK;
			for (int k = 0; k < run_len && added < count; k++) begin
				pending_beats.push_back(random_beat(run_mode));
				added++;
			end
		end
		beats_queued += count;
	endtask

	// Wait until every queued beat has gone through and its result was taken.
	task automatic drain_block();
		while (beats_accepted < beats_queued || expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_blink_limit(input logic [7:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		blink_limit <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_limit = value;
	endtask

	task automatic run_phase(input logic [7:0] limit, input int count,
		input int send_idle, input int recv_stall, input bit with_hold);
		drain_block();
		write_blink_limit(limit);
		send_idle_pct = send_idle;
		recv_stall_pct = recv_stall;
		queue_random_runs(count);
		if (with_hold) begin
			hold_requests++;
		end
	endtask

	initial begin
		refresh_beat_t beat;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset limit: every symbol code, every mode,
		// the decimal point on and off over the rightmost digit.
		send_idle_pct = 14;
		recv_stall_pct = 68;
		for (int i = 0; i < 24; i++) begin
			for (int d = 0; d < 4; d++) begin
				beat.sym[d] = 4'(i % 16);
			end
			beat.mode = ssbm_pkg::mode_t'(i / 6);
			beat.dp = 1'(i >> 2);
			pending_beats.push_back(beat);
		end
		beats_queued += 24;

		// The top limit builds up large counts; the next phase lowers the limit
		// below them, so the first visit there clears the count and flips.
		run_phase(8'd255, 300, 14, 68, 1'b0);
		run_phase(8'd0, 220, 14, 68, 1'b0);
		run_phase(8'd1, 220, 68, 14, 1'b0);
		run_phase(8'd3, 220, 68, 14, 1'b0);
		run_phase(8'($urandom_range(2, 40)), 220, 0, 0, 1'b1);
		run_phase(8'($urandom_range(4, 12)), 200, 0, 0, 1'b0);

		drain_block();
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

### seven_segment_blink_multiplexer.f
src/ssbm_pkg.sv
src/seven_segment_blink_multiplexer.sv
src/ssbm_checker.sv
tb/tb_seven_segment_blink_multiplexer.sv
